// File: sv/cave_map_majority_smoother_defines.svh
// Assertion macros shared by the cave map smoother RTL.
`ifndef CAVE_MAP_MAJORITY_SMOOTHER_DEFINES_SVH
`define CAVE_MAP_MAJORITY_SMOOTHER_DEFINES_SVH

// Same-cycle implication, checked out of reset on clk.
`define CMMS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cave map smoother: same-cycle check failed");

// Next-cycle implication, checked out of reset on clk.
`define CMMS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cave map smoother: next-cycle check failed");

`endif

// File: sv/cmms_pkg.sv
// Shared constants, types and the cell decision function of the cave map smoother.
package cmms_pkg;

	localparam int MAX_LINE   = 128;
	localparam int MAX_LINES  = 256;
	localparam int COL_W      = $clog2(MAX_LINE);
	localparam int LEN_W      = 8;
	localparam int LINES_W    = 9;
	localparam int THR_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int ROWS       = 3;
	localparam int CELLS      = 3;
	localparam int WIN_W      = ROWS * CELLS;

	localparam logic [LEN_W-1:0]   LINE_LENGTH_RST = LEN_W'(90);
	localparam logic [LINES_W-1:0] LINE_COUNT_RST  = LINES_W'(180);
	localparam logic [THR_W-1:0]   WALL_ABOVE_RST  = THR_W'(4);
	localparam logic [THR_W-1:0]   OPEN_BELOW_RST  = THR_W'(4);

	// Row 0 of every column, and the whole left column, as window masks.
	localparam logic [WIN_W-1:0] TOP_ROW_MASK  = 9'h049;
	localparam logic [WIN_W-1:0] LEFT_COL_MASK = 9'h007;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 3'd0,
		REG_LINE_COUNT  = 3'd1,
		REG_WALL_ABOVE  = 3'd2,
		REG_OPEN_BELOW  = 3'd3,
		REG_TIE_MODE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
		logic [1:0]       wr_data;
		logic [COL_W-1:0] rd_addr;
	} ls_req_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// Count walls in the window and apply the two thresholds.
	function automatic logic decide(input logic [WIN_W-1:0] w,
			input logic [THR_W-1:0] wall_above, input logic [THR_W-1:0] open_below,
			input logic tie);
		logic [CNT_W-1:0] cnt;
		cnt = '0;
		for (int k = 0; k < WIN_W; k++) begin
			cnt = cnt + CNT_W'(w[k]);
		end
		if (cnt > wall_above) begin
			return 1'b1;
		end else if (cnt < open_below) begin
			return 1'b0;
		end else begin
			return tie & w[4];
		end
	endfunction

endpackage

// File: sv/cave_map_majority_smoother.sv
// Top level of the cave map smoother: counters, window chain, line store and output register.
//
// Usage: stream a grid in raster order on the input channel (in_valid/in_stall),
// one cell per request with req_type 0 and cell_in 1 for wall. After the last cell,
// send line_length + 1 flush requests (req_type 1) to drain the remaining results;
// a flush before the frame's last cell is dropped without a result.
// Results leave on the output channel (out_valid/out_stall), one cell each; the
// result for a cell comes out one line plus one cell of requests after it, and
// last_cell marks the frame's final cell, after which a new frame may start.
// Throughput is one request per cycle while in_stall is low: the window count and
// decision fit between the line store read register and the output register. A
// result is visible in the cycle after the request that produces it is accepted.
// While out_stall holds a waiting result, in_stall is raised and nothing moves.
// The configuration port (cfg_valid/cfg_ready, always ready) writes the five
// registers; write them only between frames with nothing in flight.
// Reset clears the counters, window and out_valid and loads the configuration defaults;
// the line store needs no clearing since its first two lines are masked as outside the grid.
`include "cave_map_majority_smoother_defines.svh"

module cave_map_majority_smoother
	import cmms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic                  cell_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  new_cell,
	output logic                  last_cell,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEN_W-1:0]   line_length_q;
	logic [LINES_W-1:0] line_count_q;
	logic [THR_W-1:0]   wall_above_q;
	logic [THR_W-1:0]   open_below_q;
	logic               tie_mode_q;

	logic [COL_W-1:0]   col_pos_q;
	logic [LINES_W-1:0] line_pos_q;

	logic out_valid_q;
	logic new_cell_q;
	logic last_cell_q;

	logic [LEN_W-1:0]   eff_len;
	logic [LINES_W-1:0] eff_lines;
	logic in_acc, drain, ignore, act, v;
	logic eol, mid, endf, res_valid, res;
	logic wrap;
	logic [COL_W-1:0]   col_next;
	logic [LINES_W-1:0] line_next;
	logic [1:0]         rd_data;
	logic [ROWS-1:0]    col_new;
	logic [WIN_W-1:0]   win, w_eol, w_new;
	logic [ROWS-1:0]    cell_d [CELLS];
	logic [ROWS-1:0]    cell_q [CELLS];
	ls_req_t            ls_req;
	cell_ctl_t          cell_ctl;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RST;
			line_count_q  <= LINE_COUNT_RST;
			wall_above_q  <= WALL_ABOVE_RST;
			open_below_q  <= OPEN_BELOW_RST;
			tie_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_LINE_LENGTH: line_length_q <= cfg_data[LEN_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= cfg_data[LINES_W-1:0];
				REG_WALL_ABOVE:  wall_above_q  <= cfg_data[THR_W-1:0];
				REG_OPEN_BELOW:  open_below_q  <= cfg_data[THR_W-1:0];
				REG_TIE_MODE:    tie_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the geometry into the supported range
	always_comb begin
		if (line_length_q < LEN_W'(3)) begin
			eff_len = LEN_W'(3);
		end else if (line_length_q > LEN_W'(MAX_LINE)) begin
			eff_len = LEN_W'(MAX_LINE);
		end else begin
			eff_len = line_length_q;
		end
		if (line_count_q < LINES_W'(3)) begin
			eff_lines = LINES_W'(3);
		end else if (line_count_q > LINES_W'(MAX_LINES)) begin
			eff_lines = LINES_W'(MAX_LINES);
		end else begin
			eff_lines = line_count_q;
		end
	end

	// Request handling
	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;
	assign drain    = line_pos_q >= eff_lines;
	assign ignore   = req_type & ~drain;
	assign act      = in_acc & ~ignore;
	assign v        = drain | cell_in;

	assign eol  = (col_pos_q == '0) && (line_pos_q >= LINES_W'(2));
	assign endf = eol && ({1'b0, line_pos_q} >= ({1'b0, eff_lines} + (LINES_W + 1)'(1)));
	assign mid  = (col_pos_q != '0) && (line_pos_q != '0);

	assign win     = {cell_q[2], cell_q[1], cell_q[0]};
	assign col_new = {v, rd_data[0], rd_data[1]};

	// Treat positions outside the grid as walls
	always_comb begin
		w_eol = {{ROWS{1'b1}}, win[WIN_W-1:ROWS]};
		if (line_pos_q == LINES_W'(2)) begin
			w_eol = w_eol | TOP_ROW_MASK;
		end
		w_new = {col_new, win[WIN_W-1:ROWS]};
		if (col_pos_q == COL_W'(1)) begin
			w_new = w_new | LEFT_COL_MASK;
		end
		if (line_pos_q == LINES_W'(1)) begin
			w_new = w_new | TOP_ROW_MASK;
		end
	end

	assign res_valid = act & (eol | mid);
	assign res = eol ? decide(w_eol, wall_above_q, open_below_q, tie_mode_q)
	                 : decide(w_new, wall_above_q, open_below_q, tie_mode_q);

	// Position counters
	assign wrap = (LEN_W'(col_pos_q) + LEN_W'(1)) >= eff_len;

	always_comb begin
		col_next  = col_pos_q;
		line_next = line_pos_q;
		if (act) begin
			if (endf) begin
				col_next  = '0;
				line_next = '0;
			end else if (wrap) begin
				col_next  = '0;
				line_next = line_pos_q + LINES_W'(1);
			end else begin
				col_next  = col_pos_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q  <= '0;
			line_pos_q <= '0;
		end else begin
			col_pos_q  <= col_next;
			line_pos_q <= line_next;
		end
	end

	// Line store: read ahead at the next column so the data waits in its register
	always_comb begin
		ls_req.wr_en   = act & ~endf;
		ls_req.wr_addr = col_pos_q;
		ls_req.wr_data = {rd_data[0], v};
		ls_req.rd_addr = col_next;
	end

	cmms_line_store u_line_store (
		.clk     (clk),
		.req     (ls_req),
		.rd_data (rd_data)
	);

	// Window: a chain of column cells, new column entering on the right
	assign cell_ctl.shift = act & ~endf;
	assign cell_ctl.clear = act & endf;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == CELLS - 1) begin : g_head
			assign cell_d[i] = col_new;
		end else begin : g_link
			assign cell_d[i] = cell_q[i+1];
		end
		cmms_col_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.col_in  (cell_d[i]),
			.col_out (cell_q[i])
		);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			new_cell_q  <= res;
			last_cell_q <= endf;
		end
	end

	assign out_valid = out_valid_q;
	assign new_cell  = new_cell_q;
	assign last_cell = last_cell_q;

	`CMMS_ASSERT_NXT(a_frame_end_clears, act && endf,
		col_pos_q == '0 && line_pos_q == '0 && win == '0)
	`CMMS_ASSERT_NXT(a_ignored_holds, in_acc && ignore,
		$stable(col_pos_q) && $stable(line_pos_q) && $stable(win))
	`CMMS_ASSERT_IMP(a_result_from_request, $rose(out_valid_q), $past(in_acc))

endmodule

// File: sv/cmms_col_cell.sv
// One column cell of the 3x3 window: holds three rows, passes them left on each shift.
module cmms_col_cell
	import cmms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic [ROWS-1:0] col_in,
	output logic [ROWS-1:0] col_out
);

	logic [ROWS-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.clear) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// File: sv/cmms_line_store.sv
// Two-line buffer: one entry per column, bit 0 the previous line, bit 1 the line before.
module cmms_line_store
	import cmms_pkg::*;
(
	input  logic       clk,
	input  ls_req_t    req,
	output logic [1:0] rd_data
);

	logic [1:0] mem [MAX_LINE];
	logic [1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// File: test/cave_map_majority_smoother_tb.sv
// Self-checking testbench for the cave map majority smoother: random frames against a shadow predictor.
module cave_map_majority_smoother_tb
	import cmms_pkg::*;
();

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int RANDOM_CELLS = 320;
	localparam int MIN_FRAMES   = 6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
	localparam logic [8:0] CHECKER = 9'b101010101;
	localparam logic [8:0] RAMP    = 9'b000101111;

	typedef struct packed {
		logic flush;
		logic cell_bit;
	} cell_req_t;

	typedef struct packed {
		logic new_cell;
		logic last_cell;
	} smoothed_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = 1'b0;
	logic                  cell_in = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  new_cell;
	logic                  last_cell;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cell_req_t cell_requests[$];
	smoothed_t smoothed_due[$];

	// shadow of the registers and the neighbourhood state
	logic [LEN_W-1:0]   len_reg = LINE_LENGTH_RST;
	logic [LINES_W-1:0] lines_reg = LINE_COUNT_RST;
	logic [THR_W-1:0]   wall_thr = WALL_ABOVE_RST;
	logic [THR_W-1:0]   open_thr = OPEN_BELOW_RST;
	logic               tie_keep = 1'b0;
	logic [1:0]         prev_lines [MAX_LINE];
	logic [WIN_W-1:0]   window = '0;
	int                 col_pos = 0;
	int                 row_pos = 0;

	int  frame_len = 3;
	int  frame_lines = 3;
	int  send_idle_pct = 0;
	int  stall_pct = 0;
	logic hold_on = 1'b0;
	int  hold_count = 0;
	logic in_took = 1'b0;
	int  cycle_count = 0;
	int  mismatches = 0;
	int  results_checked = 0;
	int  requests_taken = 0;
	int  frames_done = 0;

	cave_map_majority_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.cell_in   (cell_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_cell  (new_cell),
		.last_cell (last_cell),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic cell_verdict(input logic [WIN_W-1:0] w);
		int walls;
		walls = $countones(w);
		if (walls > int'(wall_thr)) return 1'b1;
		if (walls < int'(open_thr)) return 1'b0;
		return tie_keep & w[4];
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Advance the shadow by one accepted request and queue the results it yields.
	task automatic smooth_step(input logic flush, input logic cell_bit);
		int len, lines, r, c;
		logic draining, v;
		logic [2:0] column;
		logic [WIN_W-1:0] w;
		smoothed_t res;
		len = clamp_int(int'(len_reg), 3, MAX_LINE);
		lines = clamp_int(int'(lines_reg), 3, MAX_LINES);
		r = row_pos;
		c = col_pos;
		draining = (r >= lines);
		if (flush && !draining) return;
		v = draining ? 1'b1 : cell_bit;
		if (c == 0 && r >= 2) begin
			// end of the line two back: right column lies outside the grid
			w = {3'b111, window[WIN_W-1:3]};
			if (r == 2) w |= TOP_ROW_MASK;
			res.new_cell = cell_verdict(w);
			res.last_cell = (r >= lines + 1);
			smoothed_due.push_back(res);
			if (res.last_cell) begin
				window = '0;
				col_pos = 0;
				row_pos = 0;
				frames_done++;
				return;
			end
		end
		column = {v, prev_lines[c][0], prev_lines[c][1]};
		prev_lines[c] = {prev_lines[c][0], v};
		window = {column, window[WIN_W-1:3]};
		if (c >= 1 && r >= 1) begin
			w = window;
			if (c == 1) w |= LEFT_COL_MASK;
			if (r == 1) w |= TOP_ROW_MASK;
			res.new_cell = cell_verdict(w);
			res.last_cell = 1'b0;
			smoothed_due.push_back(res);
		end
		if (c + 1 >= len) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cave_map_majority_smoother_tb NOT OK");
			$finish;
		end
	end

	// Check results first: a request taken at this edge cannot have produced one yet.
	always @(posedge clk) begin
		smoothed_t want;
		in_took <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (smoothed_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result new_cell=%0b last_cell=%0b",
						new_cell, last_cell));
				end else begin
					want = smoothed_due.pop_front();
					if (new_cell !== want.new_cell)
						flag_mismatch($sformatf("result %0d new_cell %b, expected %b",
							results_checked, new_cell, want.new_cell));
					if (last_cell !== want.last_cell)
						flag_mismatch($sformatf("result %0d last_cell %b, expected %b",
							results_checked, last_cell, want.last_cell));
					results_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LINE_LENGTH: len_reg = cfg_data[LEN_W-1:0];
					REG_LINE_COUNT:  lines_reg = cfg_data[LINES_W-1:0];
					REG_WALL_ABOVE:  wall_thr = cfg_data[THR_W-1:0];
					REG_OPEN_BELOW:  open_thr = cfg_data[THR_W-1:0];
					REG_TIE_MODE:    tie_keep = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				requests_taken++;
				smooth_step(req_type, cell_in);
			end
		end
	end

	always @(negedge clk) begin
		cell_req_t r;
		if (!in_valid || in_took) begin
			if (arst_n && cell_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				r = cell_requests.pop_front();
				in_valid <= 1'b1;
				req_type <= r.flush;
				cell_in <= r.cell_bit;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_on && hold_count < LONG_HOLD) hold_count <= hold_count + 1;
		out_stall <= (hold_on && hold_count < LONG_HOLD) || ($urandom_range(99) < stall_pct);
	end

	task automatic offer(input logic flush, input logic cell_bit);
		cell_req_t r;
		r.flush = flush;
		r.cell_bit = cell_bit;
		cell_requests.push_back(r);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int len, input int lines, input int wall, input int open_lim,
			input logic tie);
		write_reg(REG_LINE_LENGTH, len);
		write_reg(REG_LINE_COUNT, lines);
		write_reg(REG_WALL_ABOVE, wall);
		write_reg(REG_OPEN_BELOW, open_lim);
		write_reg(REG_TIE_MODE, tie);
		frame_len = clamp_int(len, 3, MAX_LINE);
		frame_lines = clamp_int(lines, 3, MAX_LINES);
	endtask

	// Hold until every request has gone in and every result has come out, then let it settle.
	task automatic wait_quiet();
		while (cell_requests.size() != 0 || in_valid || smoothed_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin send_idle_pct = 59; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 59; end
			3: begin send_idle_pct = 12; stall_pct = 12; end
			default: begin send_idle_pct = 0; stall_pct = 0; end
		endcase
	endtask

	// Queue one whole frame plus its drain; stray flushes are sprinkled in as noise.
	task automatic queue_frame(input int density, input int noise_pct, input bit pause_mid,
			output int items);
		items = 0;
		for (int row = 0; row < frame_lines; row++) begin
			if (pause_mid && row == frame_lines / 2) wait_quiet();
			for (int col = 0; col < frame_len; col++) begin
				if ($urandom_range(99) < noise_pct) offer(1'b1, 1'($urandom_range(1)));
				offer(1'b0, $urandom_range(99) < density);
				items++;
			end
		end
		for (int k = 0; k <= frame_len; k++) begin
			offer(1'($urandom_range(1)), 1'($urandom_range(1)));
			items++;
		end
	endtask

	function automatic int pick_size(input int hi_extra);
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return $urandom_range(0, 2);
		if (roll < 20) return $urandom_range(9, hi_extra);
		return $urandom_range(3, 8);
	endfunction

	function automatic int pick_threshold();
		return ($urandom_range(3) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
	endfunction

	initial begin
		int taken, budget, frame_no, noise;
		for (int i = 0; i < MAX_LINE; i++) prev_lines[i] = 2'b00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturated geometry, early flushes at frame start and mid-frame, cells in the drain
		set_idling(0);
		configure(0, 2, 4, 4, 1'b0);
		offer(1'b1, 1'b1);
		for (int k = 0; k < 9; k++) begin
			offer(1'b0, CHECKER[k]);
			if (k == 4) offer(1'b1, 1'b0);
		end
		offer(1'b1, 1'b0);
		offer(1'b0, 1'b1);
		offer(1'b0, 1'b0);
		offer(1'b1, 1'b1);
		wait_quiet();

		// overlapping thresholds: the wall rule must win
		configure(3, 3, 2, 7, 1'b1);
		for (int k = 0; k < 9; k++) offer(1'b0, RAMP[k]);
		for (int k = 0; k < 4; k++) offer(1'b1, 1'(k));
		wait_quiet();
		write_reg(REG_UNUSED, (1 << CFG_DATA_W) - 1);

		budget = 0;
		frame_no = 0;
		while (budget < RANDOM_CELLS || frame_no < MIN_FRAMES) begin
			set_idling(frame_no % 4);
			if (frame_no == 2) begin
				configure(6, 6, pick_threshold(), pick_threshold(), 1'($urandom_range(1)));
			end else begin
				configure(pick_size(20), pick_size(12), pick_threshold(), pick_threshold(),
					1'($urandom_range(1)));
			end
			noise = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 8);
			if (frame_no == 2) begin
				// stall the output for a long stretch while requests keep coming
				hold_on = 1'b1;
				queue_frame($urandom_range(0, 100), noise, 1'b0, taken);
				wait (hold_count == LONG_HOLD);
				@(posedge clk);
				hold_on = 1'b0;
			end else begin
				queue_frame($urandom_range(0, 100), noise, frame_no == 5, taken);
			end
			budget += taken;
			wait_quiet();
			frame_no++;
		end

		// widest line, reached through saturation
		set_idling(0);
		configure(255, 0, 9, 0, 1'b1);
		queue_frame(50, 2, 1'b0, taken);
		wait_quiet();

		if (smoothed_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", smoothed_due.size()));
		$display("run covered %0d frames, %0d requests taken, %0d results checked",
			frames_done, requests_taken, results_checked);
		$display("geometry from 3x3 up to 128-cell lines, thresholds 0..15, four idling mixes");
		if (mismatches == 0) begin
			$display("cave_map_majority_smoother_tb OK");
		end else begin
			$display("cave_map_majority_smoother_tb NOT OK");
		end
		$finish;
	end

endmodule
